/* rtl/sid_pkg.sv */
// ----------------------------------------------------------------------------
// sid_pkg: shared types for the signed integer divider
// Status codes and the per-request control word that rides along the array.
// ----------------------------------------------------------------------------
package sid_pkg;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_OVF  = 2'd2
    } t_sid_status;

    // Control that travels with each request through every stage.
    typedef struct packed {
        logic        valid;
        logic        neg_q;
        logic        neg_r;
        t_sid_status status;
    } t_sid_ctl;

endpackage

/* rtl/sid_prep.sv */
// ----------------------------------------------------------------------------
// sid_prep: operand conditioning
// Takes magnitudes of both operands, records result signs, flags the
// divide-by-zero and overflow cases.
// ----------------------------------------------------------------------------
module sid_prep import sid_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [DATA_WIDTH-1:0] i_dividend,
    input  logic [DATA_WIDTH-1:0] i_divisor,
    output t_sid_ctl              o_ctl,
    output logic [DATA_WIDTH-1:0] o_mag_a,
    output logic [DATA_WIDTH-1:0] o_mag_b
);

    localparam logic [DATA_WIDTH-1:0] MinVal = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic                  na;
    logic                  nb;
    t_sid_ctl              n_ctl;
    t_sid_ctl              r_ctl;
    logic [DATA_WIDTH-1:0] r_mag_a;
    logic [DATA_WIDTH-1:0] r_mag_b;

    assign na = i_dividend[DATA_WIDTH-1];
    assign nb = i_divisor[DATA_WIDTH-1];

    always_comb begin
        n_ctl.valid  = i_valid;
        n_ctl.neg_q  = na ^ nb;
        n_ctl.neg_r  = na;
        n_ctl.status = ST_OK;
        if (i_divisor == '0) begin
            n_ctl.status = ST_DIV0;
        end else if (i_dividend == MinVal && i_divisor == '1) begin
            n_ctl.status = ST_OVF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    // most negative value maps onto itself, which reads right as unsigned
    always_ff @(posedge i_clk) begin
        r_mag_a <= na ? (-i_dividend) : i_dividend;
        r_mag_b <= nb ? (-i_divisor) : i_divisor;
    end

    assign o_ctl   = r_ctl;
    assign o_mag_a = r_mag_a;
    assign o_mag_b = r_mag_b;

endmodule

/* rtl/sid_cell.sv */
// ----------------------------------------------------------------------------
// sid_cell: one restoring division step
// Shifts one dividend bit into the partial remainder, trial-subtracts the
// divisor and shifts the quotient bit in; hands everything to the next cell.
// ----------------------------------------------------------------------------
module sid_cell import sid_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_sid_ctl              i_ctl,
    input  logic [DATA_WIDTH-1:0] i_rem,
    input  logic [DATA_WIDTH-1:0] i_quo,
    input  logic [DATA_WIDTH-1:0] i_dvs,
    output t_sid_ctl              o_ctl,
    output logic [DATA_WIDTH-1:0] o_rem,
    output logic [DATA_WIDTH-1:0] o_quo,
    output logic [DATA_WIDTH-1:0] o_dvs
);

    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;
    logic                  ge;
    logic [DATA_WIDTH-1:0] n_rem;
    logic [DATA_WIDTH-1:0] n_quo;
    t_sid_ctl              r_ctl;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_quo;
    logic [DATA_WIDTH-1:0] r_dvs;

    // partial remainder stays below the divisor, so trial fits without overflow
    assign trial = {i_rem, i_quo[DATA_WIDTH-1]};
    assign diff  = trial - {1'b0, i_dvs};
    assign ge    = ~diff[DATA_WIDTH];
    assign n_rem = ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
    assign n_quo = {i_quo[DATA_WIDTH-2:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= i_dvs;
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_dvs = r_dvs;

endmodule

/* rtl/sid_fix.sv */
// ----------------------------------------------------------------------------
// sid_fix: sign restore and special cases
// Applies result signs and forces the divide-by-zero / overflow answers.
// ----------------------------------------------------------------------------
module sid_fix import sid_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_sid_ctl              i_ctl,
    input  logic [DATA_WIDTH-1:0] i_rem,
    input  logic [DATA_WIDTH-1:0] i_quo,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_quotient,
    output logic [DATA_WIDTH-1:0] o_remainder,
    output logic [1:0]            o_status
);

    localparam logic [DATA_WIDTH-1:0] MinVal = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [DATA_WIDTH-1:0] n_quo;
    logic [DATA_WIDTH-1:0] n_rem;
    logic                  r_done;
    logic [DATA_WIDTH-1:0] r_quo;
    logic [DATA_WIDTH-1:0] r_rem;
    t_sid_status           r_status;

    always_comb begin
        n_quo = i_ctl.neg_q ? (-i_quo) : i_quo;
        n_rem = i_ctl.neg_r ? (-i_rem) : i_rem;
        case (i_ctl.status)
            ST_DIV0: begin
                n_quo = '0;
                n_rem = '0;
            end
            ST_OVF: begin
                n_quo = MinVal;
                n_rem = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_status <= i_ctl.status;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_status    = r_status;

endmodule

/* rtl/signed_int_divider.sv */
// ----------------------------------------------------------------------------
// signed_int_divider: pipelined signed integer divider
// Quotient truncated toward zero, remainder with the dividend's sign.
// ----------------------------------------------------------------------------
// A new request is taken on every clock where start is high; busy never
// rises, so one division per cycle is sustained indefinitely. Each result
// appears on o_quotient/o_remainder/o_status for exactly one cycle, marked
// by o_done, after its request has passed through these registered stages
// in order: one to take magnitudes and classify, one for each of the
// DATA_WIDTH division cells, and one to restore signs.
// Results leave in request order; the receiver must take o_done as it
// comes, there is no way to hold a result back. A zero divisor gives
// status 1 with zero quotient and remainder; the most negative dividend
// over -1 gives status 2, quotient = most negative value, remainder 0.
// ----------------------------------------------------------------------------
module signed_int_divider import sid_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-1:0] i_dividend,
    input  logic [DATA_WIDTH-1:0] i_divisor,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_quotient,
    output logic [DATA_WIDTH-1:0] o_remainder,
    output logic [1:0]            o_status
);

    // chain taps: index 0 feeds cell 0, index DATA_WIDTH leaves the last cell
    t_sid_ctl              chain_ctl [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] chain_rem [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] chain_quo [DATA_WIDTH+1];
    logic [DATA_WIDTH-1:0] chain_dvs [DATA_WIDTH+1];
    logic                  accept;

    // fully pipelined: every request is taken
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // magnitude of the dividend is loaded into the quotient shifter; the
    // partial remainder starts at zero
    sid_prep #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_ctl      (chain_ctl[0]),
        .o_mag_a    (chain_quo[0]),
        .o_mag_b    (chain_dvs[0])
    );

    assign chain_rem[0] = '0;

    // one cell per quotient bit, MSB first
    for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_cell
        sid_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (chain_ctl[g]),
            .i_rem   (chain_rem[g]),
            .i_quo   (chain_quo[g]),
            .i_dvs   (chain_dvs[g]),
            .o_ctl   (chain_ctl[g+1]),
            .o_rem   (chain_rem[g+1]),
            .o_quo   (chain_quo[g+1]),
            .o_dvs   (chain_dvs[g+1])
        );
    end

    sid_fix #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_fix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (chain_ctl[DATA_WIDTH]),
        .i_rem       (chain_rem[DATA_WIDTH]),
        .i_quo       (chain_quo[DATA_WIDTH]),
        .o_done      (o_done),
        .o_quotient  (o_quotient),
        .o_remainder (o_remainder),
        .o_status    (o_status)
    );

endmodule

/* rtl/sid_chk.sv */
// ----------------------------------------------------------------------------
// sid_chk: port-level checks for the signed integer divider
// Latency, special-case results and remainder sign, bound to the top level.
// ----------------------------------------------------------------------------
module sid_chk import sid_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic [DATA_WIDTH-1:0] i_dividend,
    input logic [DATA_WIDTH-1:0] i_divisor,
    input logic                  o_done,
    input logic [DATA_WIDTH-1:0] o_quotient,
    input logic [DATA_WIDTH-1:0] o_remainder,
    input logic [1:0]            o_status
);

    localparam int                    Lat    = DATA_WIDTH + 2;
    localparam logic [DATA_WIDTH-1:0] MinVal = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // every result traces back to a request taken while busy was low
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, Lat))
        else $error("result without matching request");

    a_div0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_DIV0) |->
            (o_quotient == '0 && o_remainder == '0 && $past(i_divisor, Lat) == '0))
        else $error("divide-by-zero result wrong");

    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_OVF) |-> (o_quotient == MinVal && o_remainder == '0))
        else $error("overflow result wrong");

    // a nonzero remainder carries the dividend's sign
    a_rem_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_OK && o_remainder != '0) |->
            (o_remainder[DATA_WIDTH-1] == $past(i_dividend[DATA_WIDTH-1], Lat)))
        else $error("remainder sign differs from dividend");

endmodule

bind signed_int_divider sid_chk #(
    .DATA_WIDTH (DATA_WIDTH)
) u_sid_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_dividend  (i_dividend),
    .i_divisor   (i_divisor),
    .o_done      (o_done),
    .o_quotient  (o_quotient),
    .o_remainder (o_remainder),
    .o_status    (o_status)
);
